// ===== rtl/pfcb_pkg.sv =====
// Shared types and constants for the page framebuffer column blit block.
package pfcb_pkg;

  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 8;
  localparam int unsigned GLYPH_W     = 16;
  localparam int unsigned BYTE_W      = 8;

  typedef enum logic [1:0] {
    OP_BLIT   = 2'd0,
    OP_INVERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [6:0]         column;
    logic signed [6:0]  row_offset;
    logic [GLYPH_W-1:0] column_bits;
    logic [6:0]         span_height;
    logic [2:0]         page_index;
  } item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

// ===== rtl/page_framebuffer_column_blit.sv =====
// Top level of the page-mode monochrome frame store with column blit.
//
//   channel   direction   handshake               payload
//   in_       input       in_valid / in_stall     operation, column, row_offset,
//                                                 column_bits, span_height, page_index
//   out_      output      out_valid / out_stall   read_byte
//
// The accept edge reads the item's column from the column memory (one read and one
// write port), and the next edge modifies and writes it back, so one item per cycle
// while the input is not stalled. A read word passes from the modify stage into the
// output register. Clear, like reset, drops every per-column valid bit at once; no
// clearing pass. The input stalls only while a read in the modify stage faces a full,
// stalled output register.
module page_framebuffer_column_blit #(
  parameter int unsigned COLUMNS = pfcb_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = pfcb_pkg::PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [6:0]  in_column,
  input  logic signed [6:0] in_row_offset,
  input  logic [15:0] in_column_bits,
  input  logic [6:0]  in_span_height,
  input  logic [2:0]  in_page_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_byte
);

  localparam int unsigned W  = PAGES * 8;
  localparam int unsigned AW = $clog2(COLUMNS);

  pfcb_pkg::item_t    in_item;
  pfcb_pkg::item_t    s1_item_r, s1_item_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               accept;
  logic               s1_adv;
  logic               s1_is_read;
  logic [8:0]         in_col_ext;
  logic [8:0]         s1_col_ext;
  pfcb_pkg::mem_ctl_t mem_ctl;
  logic [W-1:0]       col_data;
  logic [W-1:0]       new_data;
  logic               mod_wr;
  logic [7:0]         mod_byte;

  always_comb begin
    in_item.operation   = pfcb_pkg::op_t'(in_operation);
    in_item.column      = in_column;
    in_item.row_offset  = in_row_offset;
    in_item.column_bits = in_column_bits;
    in_item.span_height = in_span_height;
    in_item.page_index  = in_page_index;
  end

  // The modify stage holds only when its read word cannot enter the output register.
  assign s1_is_read = s1_valid_r && (s1_item_r.operation == pfcb_pkg::OP_READ);
  assign s1_adv     = !(s1_is_read && out_valid_r && out_stall);
  assign in_stall   = !s1_adv;
  assign accept     = in_valid && !in_stall;

  assign in_col_ext = {2'b00, in_column};
  assign s1_col_ext = {2'b00, s1_item_r.column};

  // Blit and invert write back in the modify stage; a column out of range never
  // writes because the modify logic withholds the write enable.
  always_comb begin
    mem_ctl.rd_en = accept;
    mem_ctl.wr_en = s1_valid_r && mod_wr;
    mem_ctl.clr   = s1_valid_r && (s1_item_r.operation == pfcb_pkg::OP_CLEAR);
  end

  pfcb_store #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (in_col_ext[AW-1:0]),
    .wr_addr (s1_col_ext[AW-1:0]),
    .wr_data (new_data),
    .rd_data (col_data)
  );

  pfcb_modify #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_modify (
    .item      (s1_item_r),
    .old_data  (col_data),
    .wr_en     (mod_wr),
    .new_data  (new_data),
    .read_byte (mod_byte)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      if (s1_is_read) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = mod_byte;
      end
      s1_valid_nxt = accept;
      if (accept) begin
        s1_item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_item_r  <= s1_item_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;

endmodule

// ===== rtl/pfcb_store.sv =====
// Column memory with per-column valid bits and write-to-read forwarding.
module pfcb_store #(
  parameter int unsigned COLUMNS = pfcb_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = pfcb_pkg::PAGES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfcb_pkg::mem_ctl_t         ctl,
  input  logic [$clog2(COLUMNS)-1:0] rd_addr,
  input  logic [$clog2(COLUMNS)-1:0] wr_addr,
  input  logic [PAGES*8-1:0]         wr_data,
  output logic [PAGES*8-1:0]         rd_data
);

  localparam int unsigned W = PAGES * 8;

  logic [W-1:0]       mem [COLUMNS];
  logic [W-1:0]       rd_q_r;
  logic [W-1:0]       fwd_data_r;
  logic               fwd_r;
  logic               zero_r;
  logic [COLUMNS-1:0] valid_r;
  logic               same_addr;

  assign same_addr = ctl.wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // A column never written since reset or the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fwd_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else begin
      if (ctl.clr) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        fwd_r  <= same_addr;
        zero_r <= ctl.clr || (!same_addr && !valid_r[rd_addr]);
      end
    end
  end

  always_comb begin
    if (zero_r) begin
      rd_data = '0;
    end else if (fwd_r) begin
      rd_data = fwd_data_r;
    end else begin
      rd_data = rd_q_r;
    end
  end

endmodule

// ===== rtl/pfcb_modify.sv =====
// Modify logic: blit, span invert and page byte extraction on one column word.
module pfcb_modify #(
  parameter int unsigned COLUMNS = pfcb_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = pfcb_pkg::PAGES_DEF
) (
  input  pfcb_pkg::item_t                item,
  input  logic [PAGES*8-1:0]             old_data,
  output logic                           wr_en,
  output logic [PAGES*8-1:0]             new_data,
  output logic [pfcb_pkg::BYTE_W-1:0]    read_byte
);

  localparam int unsigned W     = PAGES * 8;
  localparam int unsigned EXT_W = W + pfcb_pkg::GLYPH_W;
  localparam logic signed [7:0] LAST_ROW = 8'(W - 1);
  localparam logic signed [7:0] MIN_TOP  = -8'sd15;
  localparam logic [W-1:0]      ONES     = {W{1'b1}};

  logic              col_ok;
  logic              page_ok;
  logic signed [7:0] top8;
  logic [3:0]        neg_sh;
  logic [5:0]        pos_sh;
  logic [EXT_W-1:0]  glyph_ext;
  logic [EXT_W-1:0]  placed;
  logic [W-1:0]      inv_mask;
  logic [7:0]        span_end;
  logic              blit_ok;
  logic              inv_ok;
  logic [W-1:0]      page_shift;

  always_comb begin
    col_ok    = {2'b00, item.column} < 9'(COLUMNS);
    page_ok   = {1'b0, item.page_index} < 4'(PAGES);
    top8      = {item.row_offset[6], item.row_offset};
    neg_sh    = 4'(-top8);
    pos_sh    = top8[5:0];
    glyph_ext = {{W{1'b0}}, item.column_bits};
    // Glyph rows above the screen shift out at the bottom of the word.
    placed    = top8[7] ? (glyph_ext >> neg_sh) : (glyph_ext << pos_sh);
    blit_ok   = col_ok && !(top8 > LAST_ROW) && !(top8 < MIN_TOP);

    // Rows top..top+height-1, clipped at the last row by the shift itself.
    span_end  = {2'b00, top8[5:0]} + {1'b0, item.span_height};
    inv_mask  = ~(ONES << span_end) & (ONES << pos_sh);
    inv_ok    = col_ok && !top8[7] && !(top8 > LAST_ROW) && (item.span_height != 7'd0);

    unique case (item.operation)
      pfcb_pkg::OP_BLIT: begin
        wr_en    = blit_ok;
        new_data = old_data | placed[W-1:0];
      end
      pfcb_pkg::OP_INVERT: begin
        wr_en    = inv_ok;
        new_data = old_data ^ inv_mask;
      end
      pfcb_pkg::OP_CLEAR: begin
        wr_en    = 1'b0;
        new_data = old_data;
      end
      pfcb_pkg::OP_READ: begin
        wr_en    = 1'b0;
        new_data = old_data;
      end
      default: begin
        wr_en    = 1'b0;
        new_data = old_data;
      end
    endcase

    page_shift = old_data >> {item.page_index, 3'b000};
    read_byte  = (col_ok && page_ok) ? page_shift[7:0] : '0;
  end

endmodule

// ===== rtl/pfcb_checker.sv =====
// Port-level checks for the frame store block and their binding to the top level.
module pfcb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_byte
);

  // A held word keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_byte))
    else $error("output word changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A fresh output word comes from an accepted read, by way of the modify stage.
  a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && !in_stall && (in_operation == pfcb_pkg::OP_READ), 2))
    else $error("output word without a matching read");

  // The input only stalls behind a full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind page_framebuffer_column_blit pfcb_checker u_pfcb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_byte (out_read_byte)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the page framebuffer column blit block.
module tb;
  import pfcb_pkg::*;

  // Marks a directed row whose read byte comes from the predictor, not the table.
  localparam int NO_TYPED_BYTE = -1;
  localparam int ROWS          = PAGES_DEF * 8;
  localparam int LAST_ROW      = ROWS - 1;
  localparam int RANDOM_WORDS  = 1800;
  // The last words go in with both sides running flat out.
  localparam int QUIET_FROM    = 1500;
  localparam int MAX_REPORTS   = 10;
  // Settling time after the final drain; this leaves ample margin at the end.
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [6:0]  in_column;
  logic signed [6:0] in_row_offset;
  logic [15:0] in_column_bits;
  logic [6:0]  in_span_height;
  logic [2:0]  in_page_index;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_byte;

  page_framebuffer_column_blit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_column      (in_column),
    .in_row_offset  (in_row_offset),
    .in_column_bits (in_column_bits),
    .in_span_height (in_span_height),
    .in_page_index  (in_page_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte)
  );

  // Our own copy of the picture: one 64-bit word per column, bit r is pixel row r.
  logic [ROWS-1:0] frame_model [COLUMNS_DEF];
  // Page bytes that reads have been accepted for, oldest first.
  logic [7:0]      read_bytes_due [$];
  int              mismatch_count;
  // When clear, neither side inserts idle cycles.
  bit              idle_on;
  int              stall_left;

  // One row of the directed part: the word to send and, where it is obvious,
  // the page byte a read must return.
  typedef struct {
    item_t word;
    int    typed_byte;
  } directed_row_t;

  directed_row_t directed_rows [$];

  // Free-running clock with a period of 20.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Safety net: a hung handshake ends the run as a failure.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Applies one accepted word to the picture copy. A read reports the page byte;
  // nothing else produces a result.
  task automatic apply_to_frame(input item_t w, output bit produces,
                                output logic [7:0] page_byte);
    logic [ROWS-1:0] glyph;
    logic [ROWS-1:0] span_mask;
    int              top;
    int              rows_left;
    produces  = 1'b0;
    page_byte = '0;
    top       = int'($signed(w.row_offset));
    case (w.operation)
      OP_BLIT: begin
        // A glyph starting below the last row or ending above row 0 is dropped
        // whole. Rows above row 0 are shifted out, rows past the bottom fall off
        // the top of the 64-bit word.
        if (top <= LAST_ROW && top + 15 >= 0) begin
          glyph = ROWS'(w.column_bits);
          if (top < 0) begin
            glyph = glyph >> (-top);
            top   = 0;
          end
          frame_model[w.column] = frame_model[w.column] | (glyph << top);
        end
      end
      OP_INVERT: begin
        // Toggle exactly rows top..top+height-1, clipped at the last row. A
        // negative top or an empty span leaves the column alone.
        if (top >= 0 && top <= LAST_ROW && w.span_height != 0) begin
          rows_left = ROWS - top;
          if (int'(w.span_height) < rows_left) rows_left = int'(w.span_height);
          span_mask = (rows_left >= ROWS) ? '1 : ((ROWS'(1) << rows_left) - ROWS'(1));
          frame_model[w.column] = frame_model[w.column] ^ (span_mask << top);
        end
      end
      OP_CLEAR: begin
        foreach (frame_model[c]) frame_model[c] = '0;
      end
      default: begin
        produces  = 1'b1;
        page_byte = 8'(frame_model[w.column] >> (int'(w.page_index) * 8));
      end
    endcase
  endtask

  // Presents one word, optionally after an idle burst, and holds it until the
  // block takes it. Entered and left at a falling edge.
  task automatic send_word(input item_t w, input int typed_byte);
    int         gap;
    bit         produces;
    logic [7:0] page_byte;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation   <= w.operation;
    in_column      <= w.column;
    in_row_offset  <= w.row_offset;
    in_column_bits <= w.column_bits;
    in_span_height <= w.span_height;
    in_page_index  <= w.page_index;
    in_valid       <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    // The word went in at this edge; the expected byte is queued before the
    // block can possibly return it through the modify stage and output register.
    apply_to_frame(w, produces, page_byte);
    if (produces) begin
      read_bytes_due.push_back((typed_byte == NO_TYPED_BYTE) ? page_byte : 8'(typed_byte));
    end
    @(negedge clk);
  endtask

  // Stops sending until every expected page byte has come back or DRAIN_LIMIT runs out.
  task automatic drain_results();
    int waited;
    waited   = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (read_bytes_due.size() != 0 && waited < DRAIN_LIMIT);
  endtask

  task automatic add_row(input op_t op, input int column, input int offset,
                         input int bits, input int height, input int page,
                         input int typed_byte);
    directed_row_t r;
    r.word.operation   = op;
    r.word.column      = 7'(column);
    r.word.row_offset  = 7'(offset);
    r.word.column_bits = 16'(bits);
    r.word.span_height = 7'(height);
    r.word.page_index  = 3'(page);
    r.typed_byte       = typed_byte;
    directed_rows.push_back(r);
  endtask

  // Random words are mostly aimed at a few hot columns so that reads see
  // pixels; offsets and heights mostly stay in range, with some full-range noise.
  function automatic item_t random_word();
    item_t w;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.operation = OP_BLIT;
    else if (pick < 65) w.operation = OP_INVERT;
    else if (pick < 99) w.operation = OP_READ;
    else                w.operation = OP_CLEAR;
    w.column      = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(0, 7)) : 7'($urandom);
    w.row_offset  = ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                : 7'($urandom_range(0, 79) - 16);
    w.column_bits = 16'($urandom);
    w.span_height = ($urandom_range(0, 4) == 0) ? 7'($urandom)
                                                : 7'($urandom_range(0, 64));
    w.page_index  = 3'($urandom);
    return w;
  endfunction

  // The receiver stalls in random bursts while idling is on.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every page byte the block hands over is matched against the oldest
  // expectation. A byte with nothing waiting is a failure of its own.
  always @(posedge clk) begin
    logic [7:0] due;
    if (rst_n && out_valid && !out_stall) begin
      if (read_bytes_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected read byte %02h with no read outstanding", out_read_byte);
        end
      end else begin
        due = read_bytes_due.pop_front();
        if (out_read_byte !== due) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("read byte mismatch: expected %02h, got %02h", due, out_read_byte);
          end
        end
      end
    end
  end

  initial begin
    // Every input is known from time zero.
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_BLIT;
    in_column      = '0;
    in_row_offset  = '0;
    in_column_bits = '0;
    in_span_height = '0;
    in_page_index  = '0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    foreach (frame_model[c]) frame_model[c] = '0;

    // Directed part. Reads right after reset must see an empty picture.
    add_row(OP_READ,   0,   0,  0,      0,   0, 8'h00);
    add_row(OP_READ,   127, 0,  0,      0,   7, 8'h00);
    // A full glyph at the top of column 0 fills pages 0 and 1.
    add_row(OP_BLIT,   0,   0,  16'hFFFF, 0, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   0,   0,  0,      0,   0, 8'hFF);
    add_row(OP_READ,   0,   0,  0,      0,   1, 8'hFF);
    add_row(OP_READ,   0,   0,  0,      0,   2, 8'h00);
    // A glyph that ends exactly one row above the screen changes nothing, one
    // row lower only its last row lands, on row 0.
    add_row(OP_BLIT,   127, -16, 16'hFFFF, 0, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   127, 0,  0,      0,   0, 8'h00);
    add_row(OP_BLIT,   127, -15, 16'h8000, 0, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   127, 0,  0,      0,   0, 8'h01);
    // Starting on the last row, everything past it is clipped.
    add_row(OP_BLIT,   5,   63, 16'h0003, 0, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   5,   0,  0,      0,   7, 8'h80);
    add_row(OP_BLIT,   6,   56, 16'hA5A5, 0, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   6,   0,  0,      0,   7, NO_TYPED_BYTE);
    // A full-height invert sets every page.
    add_row(OP_INVERT, 10,  0,  0,      64,  0, NO_TYPED_BYTE);
    add_row(OP_READ,   10,  0,  0,      0,   3, 8'hFF);
    // Negative offsets and an empty span invert nothing.
    add_row(OP_INVERT, 11,  -1, 0,      5,   0, NO_TYPED_BYTE);
    add_row(OP_INVERT, 11,  3,  0,      0,   0, NO_TYPED_BYTE);
    add_row(OP_INVERT, 11,  -64, 16'hFFFF, 127, 7, NO_TYPED_BYTE);
    add_row(OP_READ,   11,  0,  0,      0,   0, 8'h00);
    // A span running past the bottom stops at the last row.
    add_row(OP_INVERT, 12,  60, 0,      127, 0, NO_TYPED_BYTE);
    add_row(OP_READ,   12,  0,  0,      0,   7, 8'hF0);
    // A span shorter than a page toggles only its own rows.
    add_row(OP_INVERT, 13,  2,  0,      3,   0, NO_TYPED_BYTE);
    add_row(OP_READ,   13,  0,  0,      0,   0, 8'h1C);
    // Clear wipes every column.
    add_row(OP_CLEAR,  0,   0,  0,      0,   0, NO_TYPED_BYTE);
    add_row(OP_READ,   0,   0,  0,      0,   0, 8'h00);
    add_row(OP_READ,   10,  0,  0,      0,   3, 8'h00);

    // Synchronous reset, released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed_byte);
    end
    // Hold the sender off until the directed reads are all back.
    drain_results();

    // Random part. Idling switches on and off in long stretches, the sender
    // drains now and then, and the tail runs with no idling at all.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i >= QUIET_FROM) begin
        idle_on = 1'b0;
      end else if (i % 250 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      if (i % 400 == 399) drain_results();
      send_word(random_word(), NO_TYPED_BYTE);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (read_bytes_due.size() != 0) begin
      $display("%0d read bytes never arrived", read_bytes_due.size());
    end
    if (mismatch_count == 0 && read_bytes_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
